// ----- hdl/hvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none
package hvt_pkg;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_DIRECTION = 1'b1;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

// ----- hdl/hvt_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Quotient of a 48-bit dividend by a 32-bit divisor, truncated toward zero,
// one quotient bit per stage, with a stall-driven enable.
// ----------------------------------------------------------------------------
`default_nettype none
module hvt_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 3
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num [SW],
  input  wire logic signed [DW-1:0] den,
  output logic signed [NW:0]        quo [SW]
);
  typedef struct packed {
    logic [NW-1:0] q;
    logic [DW:0]   r;
  } lane_t;

  lane_t         st [NW+1][SW];
  logic [DW-1:0] dd [NW+1];
  logic          ng [NW+1][SW];

  always_comb begin
    dd[0] = den[DW-1] ? DW'(-den) : DW'(den);
    for (int l = 0; l < SW; l++) begin
      ng[0][l] = num[l][NW-1] ^ den[DW-1];
      st[0][l].q = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
      st[0][l].r = '0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    lane_t         s_r [SW];
    logic [DW-1:0] d_r;
    logic          n_r [SW];
    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= dd[k];
        for (int l = 0; l < SW; l++) begin
          logic [DW+1:0] t;
          t = {st[k][l].r, st[k][l].q[NW-1]} - {2'b0, dd[k]};
          n_r[l] <= ng[k][l];
          if (!t[DW+1]) begin
            s_r[l].r <= t[DW:0];
            s_r[l].q <= {st[k][l].q[NW-2:0], 1'b1};
          end else begin
            s_r[l].r <= {st[k][l].r[DW-1:0], st[k][l].q[NW-1]};
            s_r[l].q <= {st[k][l].q[NW-2:0], 1'b0};
          end
        end
      end
    end
    always_comb begin
      dd[k+1] = d_r;
      for (int l = 0; l < SW; l++) begin
        st[k+1][l] = s_r[l];
        ng[k+1][l] = n_r[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < SW; l++) begin
      quo[l] = ng[NW][l] ? -$signed({1'b0, st[NW][l].q}) : $signed({1'b0, st[NW][l].q});
    end
  end
endmodule
`default_nettype wire

// ----- hdl/homogeneous_vertex_transform.sv -----
// Throughput: one item per cycle; the whole pipeline advances when the
// output register is empty or being taken, so a stall freezes every stage.
// The divider chain, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
// Homogeneous vertex transform
// 4x4 matrix times Q vertex, with optional perspective divide by w.
// ----------------------------------------------------------------------------
`default_nettype none
module homogeneous_vertex_transform import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic signed [31:0]   in_x,
  input  wire logic signed [31:0]   in_y,
  input  wire logic signed [31:0]   in_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic                      divided,
  output logic                      saturated,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int DLAT = NW;
  localparam int SMW = 66 - FRAC_BITS;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [63:0] regs [NUM_REGS];
  logic        en;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= {32'd0, ONE};
      regs[1] <= '0;
      regs[2] <= {ONE, 32'd0};
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= {32'd0, ONE};
      regs[6] <= '0;
      regs[7] <= {ONE, 32'd0};
    end else if (cfg_valid) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  function automatic logic signed [31:0] el(input logic [63:0] r [NUM_REGS],
                                            input int c, input int rw);
    logic [63:0] w;
    w = r[c*2 + rw/2];
    return (rw % 2 == 1) ? $signed(w[63:32]) : $signed(w[31:0]);
  endfunction

  // stage 1: products
  logic              v1, c1;
  logic signed [63:0] pr [4][3];
  logic signed [31:0] tr [4];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= command;
      for (int r = 0; r < 4; r++) begin
        pr[r][0] <= 64'(in_x) * 64'(el(regs, 0, r));
        pr[r][1] <= 64'(in_y) * 64'(el(regs, 1, r));
        pr[r][2] <= 64'(in_z) * 64'(el(regs, 2, r));
        tr[r] <= (command == CMD_POINT) ? el(regs, 3, r) : '0;
      end
    end
  end

  // stage 2: row sums
  logic              v2, c2;
  logic signed [SMW-1:0] sm [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1;
      for (int r = 0; r < 4; r++) begin
        sm[r] <= SMW'(pr[r][0] >>> FRAC_BITS) + SMW'(pr[r][1] >>> FRAC_BITS)
               + SMW'(pr[r][2] >>> FRAC_BITS) + SMW'(tr[r]);
      end
    end
  end

  // stage 3: clamp
  logic              v3, c3, s3;
  logic signed [31:0] cl [4];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic st;
      st = 1'b0;
      c3 <= c2;
      for (int r = 0; r < 4; r++) begin
        if (sm[r] > SMW'(Q_MAX)) begin
          cl[r] <= Q_MAX;
          if (r < 3 || c2 == CMD_POINT) st = 1'b1;
        end else if (sm[r] < SMW'(Q_MIN)) begin
          cl[r] <= Q_MIN;
          if (r < 3 || c2 == CMD_POINT) st = 1'b1;
        end else begin
          cl[r] <= 32'(sm[r]);
        end
      end
      s3 <= st;
    end
  end

  // stage 4: divider set-up
  logic               v4, d4, s4;
  logic signed [31:0] w4;
  logic signed [NW-1:0] nm [3];
  logic signed [31:0] un4 [3];
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d4 <= (c3 == CMD_POINT) && (cl[3] != '0);
      s4 <= s3;
      w4 <= (cl[3] != '0) ? cl[3] : 32'sd1;
      for (int l = 0; l < 3; l++) begin
        nm[l] <= NW'(cl[l]) <<< FRAC_BITS;
        un4[l] <= cl[l];
      end
    end
  end

  logic signed [NW:0] qo [3];
  hvt_div #(.NW(NW), .DW(32), .SW(3)) u_div (
    .clk(clk), .en(en), .num(nm), .den(w4), .quo(qo)
  );

  // side-band delay alongside the divider
  logic               vd [DLAT];
  logic               dd [DLAT];
  logic               sd [DLAT];
  logic signed [31:0] ud [DLAT][3];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLAT; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v4;
      for (int k = 1; k < DLAT; k++) vd[k] <= vd[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= d4;
      sd[0] <= s4;
      ud[0] <= un4;
      for (int k = 1; k < DLAT; k++) begin
        dd[k] <= dd[k-1];
        sd[k] <= sd[k-1];
        ud[k] <= ud[k-1];
      end
    end
  end

  // output register: final clamp
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd[DLAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic st;
      logic signed [31:0] o [3];
      st = sd[DLAT-1];
      for (int l = 0; l < 3; l++) begin
        o[l] = ud[DLAT-1][l];
        if (dd[DLAT-1]) begin
          if (qo[l] > (NW+1)'(Q_MAX)) begin
            o[l] = Q_MAX; st = 1'b1;
          end else if (qo[l] < (NW+1)'(Q_MIN)) begin
            o[l] = Q_MIN; st = 1'b1;
          end else begin
            o[l] = 32'(qo[l]);
          end
        end
      end
      out_x <= o[0];
      out_y <= o[1];
      out_z <= o[2];
      divided <= dd[DLAT-1];
      saturated <= st;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hvt_checker.sv -----
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Port-level properties of the transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module hvt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_x,
  input wire logic        divided,
  input wire logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(divided))
    else $error("stalled result changed");
  a_backp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");
  a_cfg: assert property (@(posedge clk) cfg_ready)
    else $error("config port not ready");
endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_x(out_x), .divided(divided), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ----- test/homogeneous_vertex_transform_test.sv -----
// ----------------------------------------------------------------------------
// Homogeneous vertex transform testbench
// Drives points and directions through the block under several matrices and
// handshake pressure settings, predicts each transformed vertex and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module homogeneous_vertex_transform_test import hvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 4 + 32 + FRAC + 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic command;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic divided;
    logic saturated;
  } transformed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_POINT;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic divided, saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  homogeneous_vertex_transform #(.FRAC_BITS(FRAC)) dut (.*);

  always #2 clk = ~clk;

  logic [63:0] matrix [NUM_REGS];
  vertex_t pending_vertices [$];
  transformed_t expected_vertices [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  longint cycles = 0;

  function automatic logic signed [63:0] element(int c, int r);
    logic [63:0] w;
    w = matrix[c * 2 + r / 2];
    return (r % 2) ? $signed(w[63:32]) : $signed(w[31:0]);
  endfunction

  function automatic logic signed [63:0] clamp_q(logic signed [63:0] v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic transformed_t transform_vertex(vertex_t vin);
    logic signed [63:0] p [3];
    logic signed [63:0] v [4];
    logic signed [63:0] s;
    logic sat;
    logic point;
    transformed_t t;
    sat = 1'b0;
    point = (vin.command == CMD_POINT);
    p[0] = vin.x;
    p[1] = vin.y;
    p[2] = vin.z;
    for (int r = 0; r < 4; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++) s += (p[c] * element(c, r)) >>> FRAC;
      if (point) s += element(3, r);
      v[r] = s;
    end
    for (int r = 0; r < 3; r++) v[r] = clamp_q(v[r], sat);
    t.divided = 1'b0;
    if (point) begin
      v[3] = clamp_q(v[3], sat);
      if (v[3] != 0) begin
        t.divided = 1'b1;
        for (int r = 0; r < 3; r++) v[r] = clamp_q((v[r] <<< FRAC) / v[3], sat);
      end
    end
    t.x = v[0][31:0];
    t.y = v[1][31:0];
    t.z = v[2][31:0];
    t.saturated = sat;
    return t;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_vertices.push_back(transform_vertex({command, in_x, in_y, in_z}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          vertex_t item;
          item = pending_vertices.pop_front();
          in_valid <= 1'b1;
          command <= item.command;
          in_x <= item.x;
          in_y <= item.y;
          in_z <= item.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %h %h %h", out_x, out_y, out_z);
        end else begin
          transformed_t e;
          e = expected_vertices.pop_front();
          if (e !== {out_x, out_y, out_z, divided, saturated}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h d%b s%b got %h %h %h d%b s%b",
                       e.x, e.y, e.z, e.divided, e.saturated,
                       out_x, out_y, out_z, divided, saturated);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int n);
    vertex_t item;
    for (int i = 0; i < n; i++) begin
      item.command = $urandom_range(1);
      item.x = rand_coord();
      item.y = rand_coord();
      item.z = rand_coord();
      pending_vertices.push_back(item);
    end
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    matrix[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_pair(int scale);
    logic [31:0] lo, hi;
    lo = (scale == 0) ? $urandom : $urandom_range(0, 2 * scale) - scale;
    hi = (scale == 0) ? $urandom : $urandom_range(0, 2 * scale) - scale;
    return {hi, lo};
  endfunction

  initial begin
    vertex_t item;
    matrix[0] = 64'd65536;
    matrix[1] = 64'd0;
    matrix[2] = 64'd65536 << 32;
    matrix[3] = 64'd0;
    matrix[4] = 64'd0;
    matrix[5] = 64'd65536;
    matrix[6] = 64'd0;
    matrix[7] = 64'd65536 << 32;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, extremes, both commands
    for (int c = 0; c < 2; c++) begin
      item.command = c[0];
      item = '{c[0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
      pending_vertices.push_back(item);
      item = '{c[0], 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      pending_vertices.push_back(item);
      item = '{c[0], 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
      pending_vertices.push_back(item);
      item = '{c[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      pending_vertices.push_back(item);
    end
    drain();

    // zero w, large w causing sum overflow and quotient overflow
    write_reg(7, 64'h0);
    write_reg(6, {32'h7FFF_FFFF, 32'h8000_0000});
    for (int i = 0; i < 4; i++) begin
      item = '{CMD_POINT, rand_coord(), rand_coord(), rand_coord()};
      pending_vertices.push_back(item);
    end
    drain();
    write_reg(7, {32'h0000_0001, 32'h7FFF_FFFF});
    write_reg(1, {32'h7FFF_FFFF, 32'h0001_0000});
    for (int i = 0; i < 6; i++) begin
      item = '{i[0], rand_coord(), rand_coord(), rand_coord()};
      pending_vertices.push_back(item);
    end
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case (phase % 4)
          0: write_reg(r, rand_pair(32'h0002_0000));
          1: write_reg(r, rand_pair(0));
          2: write_reg(r, (r % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_8000_0000);
          default: write_reg(r, rand_pair(32'h0000_4000));
        endcase
      end
      case (phase % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 62; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 62; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (phase == 4) hold_cycles = 3 * LATENCY;
      queue_random(80);
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- homogeneous_vertex_transform.f -----
hdl/hvt_pkg.sv
hdl/hvt_div.sv
hdl/homogeneous_vertex_transform.sv
hdl/hvt_checker.sv
test/homogeneous_vertex_transform_test.sv
